// File: rtl/core/wrca_pkg.sv
// wrca_pkg: shared widths, register indexes, request codes and reset values
// for the windowed rms change alarm. No dependencies.
package wrca_pkg;

  localparam int MAX_WINDOW_DEF = 256;
  localparam int SAMPLE_W       = 16;
  localparam int SQ_W           = 32;
  localparam int RMS_W          = 16;
  localparam int COUNT_W        = 32;
  localparam int WLEN_W         = 9;
  localparam int LEVEL_W        = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int FRAC_BITS      = 14;
  localparam int CLR_W          = 2 * LEVEL_W - FRAC_BITS;

  localparam logic [WLEN_W-1:0]  WINDOW_LEN_RST      = WLEN_W'(32);
  localparam logic [LEVEL_W-1:0] ALARM_LEVEL_RST     = LEVEL_W'(4096);
  localparam logic [LEVEL_W-1:0] CLEAR_FRACTION_RST  = LEVEL_W'(13107);
  localparam logic [WLEN_W-1:0]  WINDOW_MIN          = WLEN_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LEN      = 2'd0,
    CFG_ALARM_LEVEL     = 2'd1,
    CFG_CLEAR_FRACTION  = 2'd2
  } cfg_reg_t;

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

endpackage

// File: rtl/core/wrca_ram.sv
// wrca_ram: generic single-write, single-read RAM with registered read data.
// Defaults come from wrca_pkg.
module wrca_ram #(
  parameter int WIDTH = wrca_pkg::SQ_W,
  parameter int DEPTH = wrca_pkg::MAX_WINDOW_DEF
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/wrca_div.sv
// wrca_div: restoring divider, one quotient bit per cycle.
// Standalone; used by windowed_rms_change_alarm for sum / fill.
module wrca_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_diff;

  assign rem_sh   = {rem, quo[NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(NUM_W);
        rem   <= '0;
        quo   <= num;
        den_q <= den;
      end else if (busy) begin
        if (!rem_diff[DEN_W]) begin
          rem <= rem_diff[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/wrca_sqrt.sv
// wrca_sqrt: digit-by-digit integer square root, one root bit per cycle.
// Standalone; used by windowed_rms_change_alarm on the mean square.
module wrca_sqrt #(
  parameter int IN_W = 40
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [IN_W-1:0]         val,
  output logic                    done,
  output logic [(IN_W+1)/2-1:0]   root
);

  localparam int RT_W  = (IN_W + 1) / 2;
  localparam int CNT_W = $clog2(RT_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [2*RT_W-1:0] rad;
  logic [RT_W:0]     rem;
  logic [RT_W+2:0]   rem_t;
  logic [RT_W+2:0]   trial;
  logic [RT_W+2:0]   diff;

  assign rem_t = {rem, rad[2*RT_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign diff  = rem_t - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(RT_W);
        rad  <= (2*RT_W)'(val);
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= {rad[2*RT_W-3:0], 2'b00};
        if (!diff[RT_W+2]) begin
          rem  <= diff[RT_W:0];
          root <= {root[RT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_t[RT_W:0];
          root <= {root[RT_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/windowed_rms_change_alarm.sv
// windowed_rms_change_alarm: top level. Ring of squared differences in wrca_ram,
// running sum, wrca_div for the mean and wrca_sqrt for the rms; uses wrca_pkg.
//
// Input channel (in_valid/in_ready): one word per request, req_type selects
// record (sample) or clear. Output channel (out_valid/out_ready): one word per
// request with rms_value, alarm flags and the two wrapping counters.
// Items are handled one at a time; in_ready is high only while the control is
// idle. A recorded sample after the first one runs accept, ring read, ring
// update, the divider on the SUM_W-bit sum (40 bits at MAX_WINDOW = 256) and
// the square root, then the alarm decision and the final step; in_ready rises
// again together with out_valid. A seeding sample or a clear request goes from
// acceptance straight to the final step.
// The result sits in an output register; if the receiver stalls, the next item
// is held in its final step until that register frees up.
// Reset (rst, synchronous) restores the default registers and zeroes all
// state; the ring itself is not swept: entries count as zero until the fill
// count reaches the window. A write to a mapped register clears state alike.
module windowed_rms_change_alarm #(
  parameter int MAX_WINDOW = wrca_pkg::MAX_WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [wrca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wrca_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic signed [wrca_pkg::SAMPLE_W-1:0] sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [wrca_pkg::RMS_W-1:0]        rms_value,
  output logic                              alarm_high,
  output logic                              alarm_raised,
  output logic                              alarm_cleared,
  output logic [wrca_pkg::COUNT_W-1:0]      record_count,
  output logic [wrca_pkg::COUNT_W-1:0]      alarm_count
);

  import wrca_pkg::*;

  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W = SQ_W + $clog2(MAX_WINDOW);
  localparam int RT_W  = (SUM_W + 1) / 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_UPD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SQ_GO,
    S_SQ_WAIT,
    S_JUDGE,
    S_FINISH
  } state_t;

  state_t state;

  logic [WLEN_W-1:0]   window_len;
  logic [LEVEL_W-1:0]  alarm_level;
  logic [LEVEL_W-1:0]  clear_fraction;
  logic [CLR_W-1:0]    clr_level;
  logic [WIN_W-1:0]    eff_win;

  logic [PTR_W-1:0]    write_pos;
  logic [WIN_W-1:0]    fill_count;
  logic                seeded;
  logic signed [SAMPLE_W-1:0] last_sample;
  logic [SUM_W-1:0]    square_sum;
  logic                high_state;
  logic [RMS_W-1:0]    last_rms;
  logic [COUNT_W-1:0]  records;
  logic [COUNT_W-1:0]  alarms;

  logic [SAMPLE_W-1:0] abs_diff;
  logic [SQ_W-1:0]     sq_val;
  logic [SQ_W-1:0]     old_val;
  logic                raised;
  logic                cleared;

  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0]   diff_mag;
  logic [RMS_W-1:0]    rv;
  logic                accept;
  logic                cfg_hit;
  logic                clear_now;

  logic [SQ_W-1:0]     ram_rdata;
  logic                div_start;
  logic                div_done;
  logic [SUM_W-1:0]    div_quo;
  logic                sq_start;
  logic                sq_done;
  logic [RT_W-1:0]     sq_root;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign div_start = (state == S_DIV_GO);
  assign sq_start  = (state == S_SQ_GO);

  assign diff     = {sample[SAMPLE_W-1], sample} - {last_sample[SAMPLE_W-1], last_sample};
  assign diff_mag = diff[SAMPLE_W] ? -diff : diff;
  assign rv       = (|sq_root[RT_W-1:RMS_W]) ? {RMS_W{1'b1}} : sq_root[RMS_W-1:0];

  always_comb begin
    if (window_len < WINDOW_MIN) begin
      eff_win = WIN_W'(2);
    end else if (32'(window_len) > 32'(MAX_WINDOW)) begin
      eff_win = WIN_W'(MAX_WINDOW);
    end else begin
      eff_win = WIN_W'(window_len);
    end
  end

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_LEN, CFG_ALARM_LEVEL, CFG_CLEAR_FRACTION: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  assign clear_now = cfg_hit || (accept && req_type == REQ_CLEAR);

  always_ff @(posedge clk) begin
    clr_level <= CLR_W'((32'(alarm_level) * 32'(clear_fraction)) >> FRAC_BITS);
  end

  wrca_ram #(
    .WIDTH (SQ_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (state == S_UPD),
    .waddr (write_pos),
    .wdata (sq_val),
    .re    (accept),
    .raddr (write_pos),
    .rdata (ram_rdata)
  );

  wrca_div #(
    .NUM_W (SUM_W),
    .DEN_W (WIN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (square_sum),
    .den   (fill_count),
    .done  (div_done),
    .quo   (div_quo)
  );

  wrca_sqrt #(
    .IN_W (SUM_W)
  ) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .val   (div_quo),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      window_len      <= WINDOW_LEN_RST;
      alarm_level     <= ALARM_LEVEL_RST;
      clear_fraction  <= CLEAR_FRACTION_RST;
      write_pos       <= '0;
      fill_count      <= '0;
      seeded          <= 1'b0;
      last_sample     <= '0;
      square_sum      <= '0;
      high_state      <= 1'b0;
      last_rms        <= '0;
      records         <= '0;
      alarms          <= '0;
      raised          <= 1'b0;
      cleared         <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WINDOW_LEN:      window_len      <= cfg_data[WLEN_W-1:0];
          CFG_ALARM_LEVEL:     alarm_level     <= cfg_data[LEVEL_W-1:0];
          CFG_CLEAR_FRACTION:  clear_fraction  <= cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            raised  <= 1'b0;
            cleared <= 1'b0;
            if (req_type == REQ_CLEAR) begin
              state <= S_FINISH;
            end else if (!seeded) begin
              last_sample <= sample;
              seeded      <= 1'b1;
              records     <= records + COUNT_W'(1);
              state       <= S_FINISH;
            end else begin
              abs_diff    <= diff_mag[SAMPLE_W-1:0];
              last_sample <= sample;
              records     <= records + COUNT_W'(1);
              state       <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          sq_val  <= SQ_W'(abs_diff) * SQ_W'(abs_diff);
          old_val <= (fill_count == eff_win) ? ram_rdata : '0;
          state   <= S_UPD;
        end
        S_UPD: begin
          square_sum <= square_sum - SUM_W'(old_val) + SUM_W'(sq_val);
          if (WIN_W'(write_pos) + WIN_W'(1) == eff_win) begin
            write_pos <= '0;
          end else begin
            write_pos <= write_pos + PTR_W'(1);
          end
          if (fill_count < eff_win) begin
            fill_count <= fill_count + WIN_W'(1);
          end
          state <= S_DIV_GO;
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            state <= S_SQ_GO;
          end
        end
        S_SQ_GO: state <= S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (sq_done) begin
            state <= S_JUDGE;
          end
        end
        S_JUDGE: begin
          last_rms <= rv;
          if (!high_state && rv > alarm_level) begin
            high_state <= 1'b1;
            alarms     <= alarms + COUNT_W'(1);
            raised     <= 1'b1;
          end else if (high_state && CLR_W'(rv) < clr_level) begin
            high_state <= 1'b0;
            cleared    <= 1'b1;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            rms_value     <= last_rms;
            alarm_high    <= high_state;
            alarm_raised  <= raised;
            alarm_cleared <= cleared;
            record_count  <= records;
            alarm_count   <= alarms;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (clear_now) begin
        write_pos   <= '0;
        fill_count  <= '0;
        seeded      <= 1'b0;
        last_sample <= '0;
        square_sum  <= '0;
        high_state  <= 1'b0;
        last_rms    <= '0;
        records     <= '0;
        alarms      <= '0;
      end
    end
  end

endmodule

// File: rtl/core/wrca_checker.sv
// wrca_checker: port-level assertions for windowed_rms_change_alarm,
// attached to the top level by the bind below. No package use.
module wrca_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        alarm_high,
  input logic        alarm_raised,
  input logic        alarm_cleared,
  input logic [15:0] rms_value,
  input logic [31:0] alarm_count
);

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(alarm_raised && alarm_cleared))
    else $error("raised and cleared in one word");

  a_raise_sets_high: assert property (@(posedge clk) disable iff (rst)
    (out_valid && alarm_raised) |-> alarm_high)
    else $error("alarm raised but not high");

  a_clear_drops_high: assert property (@(posedge clk) disable iff (rst)
    (out_valid && alarm_cleared) |-> !alarm_high)
    else $error("alarm cleared but still high");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(rms_value) && $stable(alarm_count)))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind windowed_rms_change_alarm wrca_checker u_wrca_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .alarm_high    (alarm_high),
  .alarm_raised  (alarm_raised),
  .alarm_cleared (alarm_cleared),
  .rms_value     (rms_value),
  .alarm_count   (alarm_count)
);

// File: tb/sv/windowed_rms_change_alarm_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for windowed_rms_change_alarm: a queue-fed driver and a
// monitor with random stalls, checked against an in-bench rms/alarm predictor.
// Depends on wrca_pkg and the windowed_rms_change_alarm RTL.
module windowed_rms_change_alarm_test;
  import wrca_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_REPORTS = 40;
  localparam int RING_DEPTH = MAX_WINDOW_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  typedef struct {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] smp;
  } rms_req_t;

  typedef struct packed {
    logic [RMS_W-1:0]   rms;
    logic               high;
    logic               raised;
    logic               cleared;
    logic [COUNT_W-1:0] recs;
    logic [COUNT_W-1:0] alarms;
  } alarm_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW_LEN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = REQ_RECORD;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [RMS_W-1:0] rms_value;
  logic alarm_high;
  logic alarm_raised;
  logic alarm_cleared;
  logic [COUNT_W-1:0] record_count;
  logic [COUNT_W-1:0] alarm_count;

  windowed_rms_change_alarm dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .rms_value(rms_value),
    .alarm_high(alarm_high),
    .alarm_raised(alarm_raised),
    .alarm_cleared(alarm_cleared),
    .record_count(record_count),
    .alarm_count(alarm_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [WLEN_W-1:0]  win_len;
  logic [LEVEL_W-1:0] thresh;
  logic [LEVEL_W-1:0] clr_frac;
  logic [SQ_W-1:0]    sq_ring [RING_DEPTH];
  int                 ring_pos;
  int                 ring_fill;
  bit                 seeded;
  logic signed [SAMPLE_W-1:0] prev_smp;
  logic [39:0]        sq_sum;
  bit                 alarm_on;
  logic [RMS_W-1:0]   last_rv;
  logic [COUNT_W-1:0] rec_total;
  logic [COUNT_W-1:0] alarm_total;

  rms_req_t    pending_reqs[$];
  alarm_word_t expected_words[$];
  rms_req_t    cur_req;
  alarm_word_t next_word;
  int          err_count = 0;
  int          cycles = 0;
  int          in_gap = 0;
  int          out_stall = 0;
  int          draw;
  bit          in_quiet = 1'b0;
  bit          out_quiet = 1'b0;

  function automatic void clear_model();
    for (int i = 0; i < RING_DEPTH; i++) sq_ring[i] = '0;
    ring_pos = 0;
    ring_fill = 0;
    seeded = 1'b0;
    prev_smp = '0;
    sq_sum = '0;
    alarm_on = 1'b0;
    last_rv = '0;
    rec_total = '0;
    alarm_total = '0;
  endfunction

  function automatic void model_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_WINDOW_LEN: begin
        win_len = val[WLEN_W-1:0];
        clear_model();
      end
      CFG_ALARM_LEVEL: begin
        thresh = val;
        clear_model();
      end
      CFG_CLEAR_FRACTION: begin
        clr_frac = val;
        clear_model();
      end
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic alarm_word_t predict_alarm(rms_req_t r);
    alarm_word_t w;
    logic signed [SAMPLE_W:0] diff;
    logic [SAMPLE_W:0] mag;
    logic [SQ_W-1:0] sq;
    logic [63:0] rv;
    logic [63:0] clr_level;
    int span;
    logic rise;
    logic fall;
    rise = 1'b0;
    fall = 1'b0;
    if (r.kind == REQ_CLEAR) begin
      clear_model();
      return '0;
    end
    if (!seeded) begin
      prev_smp = r.smp;
      seeded = 1'b1;
    end else begin
      span = win_len < WINDOW_MIN ? int'(WINDOW_MIN) :
             (win_len > RING_DEPTH ? RING_DEPTH : int'(win_len));
      diff = $signed({r.smp[SAMPLE_W-1], r.smp}) - $signed({prev_smp[SAMPLE_W-1], prev_smp});
      mag = diff[SAMPLE_W] ? -diff : diff;
      sq = SQ_W'(mag) * SQ_W'(mag);
      prev_smp = r.smp;
      ring_pos = ring_pos % span;
      sq_sum = sq_sum - 40'(sq_ring[ring_pos]) + 40'(sq);
      sq_ring[ring_pos] = sq;
      ring_pos = (ring_pos + 1) % span;
      if (ring_fill < span) ring_fill++;
      rv = floor_root(64'(sq_sum) / 64'(ring_fill));
      if (rv > 64'hFFFF) rv = 64'hFFFF;
      last_rv = rv[RMS_W-1:0];
      clr_level = (64'(thresh) * 64'(clr_frac)) >> FRAC_BITS;
      if (!alarm_on && rv > 64'(thresh)) begin
        alarm_on = 1'b1;
        alarm_total++;
        rise = 1'b1;
      end else if (alarm_on && rv < clr_level) begin
        alarm_on = 1'b0;
        fall = 1'b1;
      end
    end
    rec_total++;
    w.rms = last_rv;
    w.high = alarm_on;
    w.raised = rise;
    w.cleared = fall;
    w.recs = rec_total;
    w.alarms = alarm_total;
    return w;
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words still pending", $time, expected_words.size());
      $display("Some tests failed");
      $finish;
    end else if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_words.push_back(predict_alarm(cur_req));
        if ($urandom_range(0, 63) == 0) in_quiet = !in_quiet;
        in_gap = pick_gap(in_quiet);
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        req_type <= cur_req.kind;
        sample <= cur_req.smp;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v,
                             bit bad);
    if (bad) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  task automatic check_word();
    alarm_word_t exp_w;
    if (expected_words.size() == 0) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: unexpected word, expected none, got rms %0d", $time, rms_value);
    end else begin
      exp_w = expected_words.pop_front();
      check_field("rms_value", exp_w.rms, rms_value, exp_w.rms !== rms_value);
      check_field("alarm_high", exp_w.high, alarm_high, exp_w.high !== alarm_high);
      check_field("alarm_raised", exp_w.raised, alarm_raised, exp_w.raised !== alarm_raised);
      check_field("alarm_cleared", exp_w.cleared, alarm_cleared,
                  exp_w.cleared !== alarm_cleared);
      check_field("record_count", exp_w.recs, record_count, exp_w.recs !== record_count);
      check_field("alarm_count", exp_w.alarms, alarm_count, exp_w.alarms !== alarm_count);
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_word();
    if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) out_quiet = !out_quiet;
      draw = pick_gap(out_quiet);
      if (draw == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_stall = draw - 1;
        out_ready <= 1'b0;
      end
    end
  end

  task automatic push_rec(logic signed [SAMPLE_W-1:0] v);
    rms_req_t r;
    r.kind = REQ_RECORD;
    r.smp = v;
    pending_reqs.push_back(r);
  endtask

  task automatic push_clr();
    rms_req_t r;
    r.kind = REQ_CLEAR;
    r.smp = SAMPLE_W'($urandom);
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_words.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    model_write(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(logic [CFG_DATA_W-1:0] wl, logic [CFG_DATA_W-1:0] th,
                         logic [CFG_DATA_W-1:0] fr);
    case ($urandom_range(0, 2))
      0: begin
        write_reg(CFG_WINDOW_LEN, wl);
        write_reg(CFG_ALARM_LEVEL, th);
        write_reg(CFG_CLEAR_FRACTION, fr);
      end
      1: begin
        write_reg(CFG_CLEAR_FRACTION, fr);
        write_reg(CFG_WINDOW_LEN, wl);
        write_reg(CFG_ALARM_LEVEL, th);
      end
      default: begin
        write_reg(CFG_ALARM_LEVEL, th);
        write_reg(CFG_CLEAR_FRACTION, fr);
        write_reg(CFG_WINDOW_LEN, wl);
      end
    endcase
  endtask

  // segments of one step range each, so the rms rises and falls across the thresholds
  task automatic add_random(int n);
    logic signed [SAMPLE_W-1:0] cur;
    int seg;
    int mode;
    int step;
    cur = SAMPLE_W'($urandom);
    while (n > 0) begin
      seg = $urandom_range(4, 40);
      mode = $urandom_range(0, 3);
      for (int k = 0; k < seg && n > 0; k++) begin
        if ($urandom_range(0, 49) == 0) begin
          push_clr();
        end else begin
          case (mode)
            0: step = $urandom_range(0, 128) - 64;
            1: step = $urandom_range(0, 4096) - 2048;
            2: step = $urandom_range(0, 24000) - 12000;
            default: step = 0;
          endcase
          if (mode == 3) cur = SAMPLE_W'($urandom);
          else cur = cur + SAMPLE_W'(step);
          push_rec(cur);
        end
        n--;
      end
    end
  endtask

  initial begin
    win_len = WINDOW_LEN_RST;
    thresh = ALARM_LEVEL_RST;
    clr_frac = CLEAR_FRACTION_RST;
    clear_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // defaults: seeding, full-scale swings, clear while the alarm is high
    push_clr();
    push_rec(16'sh0000);
    push_rec(16'sh7FFF);
    push_rec(-16'sh8000);
    push_rec(16'sh7FFF);
    push_rec(16'sh7FFF);
    push_clr();
    push_rec(-16'sh8000);
    push_rec(-16'sh8000);
    push_rec(16'sh0001);
    push_rec(-16'sh0001);
    drain();

    // short window: raise, hold, clear, re-raise
    set_all(16'd2, 16'd4096, 16'd16384);
    push_rec(16'sh0000);
    push_rec(16'sh2000);
    push_rec(16'sh2000);
    push_rec(16'sh2000);
    push_rec(16'sh0000);
    push_rec(16'sh0000);
    drain();
    // unmapped index must not disturb state
    write_reg(CFG_NO_REG, 16'hFFFF);
    push_rec(16'sh4000);
    push_rec(16'sh4000);
    drain();

    set_all(16'hFE02, 16'd0, 16'd0);
    add_random(90);
    drain();
    set_all(16'd256, 16'd65535, 16'd65535);
    add_random(100);
    drain();
    set_all(16'd0, 16'd4096, 16'd65535);
    add_random(100);
    drain();
    set_all(16'd1, 16'd2000, 16'd8000);
    add_random(100);
    drain();
    set_all(16'd511, 16'd8192, 16'd12000);
    add_random(100);
    drain();
    set_all(16'd300, 16'd1500, 16'd16384);
    add_random(100);
    drain();
    set_all(16'($urandom_range(2, 64)), 16'($urandom_range(500, 9000)),
            16'($urandom_range(4000, 30000)));
    add_random(110);
    drain();
    set_all(16'($urandom), 16'($urandom), 16'($urandom));
    add_random(80);
    drain();

    repeat (80) @(posedge clk);
    if (expected_words.size() != 0) begin
      err_count++;
      $display("%0t: %0d words never arrived, expected 0", $time, expected_words.size());
    end
    if (err_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
